@@ rtl/dhap_pkg.sv @@
// ----------------------------------------------------------------------------
// dhap_pkg
// Shared types and constants for the Diameter header and AVP parser.
// ----------------------------------------------------------------------------
package dhap_pkg;

  localparam int          POSITION_BITS_DEF = 24;
  localparam int          HDR_LEN           = 20;
  localparam logic [31:0] TARGET_RESET      = 32'd268;
  localparam logic [7:0]  REQ_MASK          = 8'h80;
  localparam logic [7:0]  VENDOR_MASK       = 8'h80;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_SHORT     = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_request;
    logic [23:0] command_id;
    logic [31:0] hop_by_hop;
    logic [31:0] result_value;
  } out_word_t;

endpackage

@@ rtl/dhap_core.sv @@
// ----------------------------------------------------------------------------
// dhap_core
// Per-message state: header capture and AVP walk, one byte per step.
// ----------------------------------------------------------------------------
module dhap_core #(
  parameter int POSITION_BITS = dhap_pkg::POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  dhap_pkg::in_word_t in_word,
  input  logic [31:0]        target,
  output dhap_pkg::out_word_t res
);

  localparam int PB = POSITION_BITS;
  localparam int SW = ((PB > 24) ? PB : 24) + 2;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_FOUND  = 4'b0100,
    PH_BAD    = 4'b1000
  } phase_t;

  logic [PB-1:0] pos_r, pos_nxt;
  logic [SW-1:0] start_r, start_nxt;
  logic [63:0]   hdr_r, hdr_nxt;
  logic [31:0]   data_r, data_nxt;
  phase_t        phase_r, phase_nxt;
  logic          req_r, req_nxt;
  logic [23:0]   cmd_r, cmd_nxt;
  logic [31:0]   hop_r, hop_nxt;

  logic [PB-1:0] pos_u;
  logic [SW-1:0] start_u;
  logic [63:0]   hdr_u;
  logic [31:0]   data_u;
  phase_t        phase_u;
  logic          req_u;
  logic [23:0]   cmd_u;
  logic [31:0]   hop_u;

  logic [7:0]    b;
  logic          at_max;
  logic [SW-1:0] pos_ext;
  logic          ge;
  logic [SW-1:0] diff;
  logic [63:0]   hdr_sh;
  logic [23:0]   avp_len;
  logic [24:0]   avp_pad;
  logic          is_short;
  logic [1:0]    status;

  always_comb begin
    b        = in_word.data_byte;
    at_max   = &pos_r;
    pos_ext  = SW'(pos_r);
    ge       = pos_ext >= start_r;
    diff     = pos_ext - start_r;
    hdr_sh   = {hdr_r[55:0], b};
    avp_len  = hdr_sh[23:0];
    avp_pad  = ({1'b0, avp_len} + 25'd3) & ~25'd3;
    is_short = !at_max && (pos_r < PB'(dhap_pkg::HDR_LEN - 1));

    pos_u   = pos_r;
    start_u = start_r;
    hdr_u   = hdr_r;
    data_u  = data_r;
    phase_u = phase_r;
    req_u   = req_r;
    cmd_u   = cmd_r;
    hop_u   = hop_r;

    if (!at_max) begin
      pos_u = pos_r + PB'(1);
      if (pos_r < PB'(dhap_pkg::HDR_LEN)) begin
        if (pos_r == PB'(4)) begin
          req_u = |(b & dhap_pkg::REQ_MASK);
        end else if (pos_r >= PB'(5) && pos_r <= PB'(7)) begin
          cmd_u = {cmd_r[15:0], b};
        end else if (pos_r >= PB'(12) && pos_r <= PB'(15)) begin
          hop_u = {hop_r[23:0], b};
        end
      end else begin
        unique case (phase_r)
          PH_SEARCH: begin
            if (ge && diff < SW'(8)) begin
              hdr_u = hdr_sh;
              if (diff[2:0] == 3'd7) begin
                hdr_u = '0;
                if (avp_len < 24'd8) begin
                  phase_u = PH_BAD;
                end else if (hdr_sh[63:32] == target) begin
                  phase_u = PH_DATA;
                  start_u = start_r + ((|(hdr_sh[31:24] & dhap_pkg::VENDOR_MASK)) ?
                                       SW'(12) : SW'(8));
                end else begin
                  start_u = start_r + SW'(avp_pad);
                end
              end
            end
          end
          PH_DATA: begin
            if (ge && diff < SW'(4)) begin
              data_u = {data_r[23:0], b};
              if (diff[1:0] == 2'd3) begin
                phase_u = PH_FOUND;
              end
            end
          end
          PH_FOUND: begin
          end
          PH_BAD: begin
          end
          default: begin
          end
        endcase
      end
    end

    priority if (phase_u == PH_FOUND) begin
      status = dhap_pkg::ST_FOUND;
    end else if (phase_u == PH_BAD) begin
      status = dhap_pkg::ST_MALFORMED;
    end else begin
      status = dhap_pkg::ST_NOT_FOUND;
    end

    if (is_short) begin
      res = '0;
      res.status = dhap_pkg::ST_SHORT;
    end else begin
      res.status       = status;
      res.is_request   = req_u;
      res.command_id   = cmd_u;
      res.hop_by_hop   = hop_u;
      res.result_value = (status == dhap_pkg::ST_FOUND) ? data_u : 32'd0;
    end

    pos_nxt   = pos_r;
    start_nxt = start_r;
    hdr_nxt   = hdr_r;
    data_nxt  = data_r;
    phase_nxt = phase_r;
    req_nxt   = req_r;
    cmd_nxt   = cmd_r;
    hop_nxt   = hop_r;
    if (step) begin
      if (in_word.last) begin
        pos_nxt   = '0;
        start_nxt = SW'(dhap_pkg::HDR_LEN);
        hdr_nxt   = '0;
        data_nxt  = '0;
        phase_nxt = PH_SEARCH;
        req_nxt   = 1'b0;
        cmd_nxt   = '0;
        hop_nxt   = '0;
      end else begin
        pos_nxt   = pos_u;
        start_nxt = start_u;
        hdr_nxt   = hdr_u;
        data_nxt  = data_u;
        phase_nxt = phase_u;
        req_nxt   = req_u;
        cmd_nxt   = cmd_u;
        hop_nxt   = hop_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= SW'(dhap_pkg::HDR_LEN);
      hdr_r   <= '0;
      data_r  <= '0;
      phase_r <= PH_SEARCH;
      req_r   <= 1'b0;
      cmd_r   <= '0;
      hop_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      hdr_r   <= hdr_nxt;
      data_r  <= data_nxt;
      phase_r <= phase_nxt;
      req_r   <= req_nxt;
      cmd_r   <= cmd_nxt;
      hop_r   <= hop_nxt;
    end
  end

endmodule

@@ rtl/diameter_header_avp_parser_unit.sv @@
// ----------------------------------------------------------------------------
// diameter_header_avp_parser_unit
// The summary word is registered and appears in the cycle after the last byte is taken.
// Throughput: one byte per cycle unless stalled; the byte walk and capture run in one pass.
// A last byte waits only while a previous summary is still stalled.
// Reset: synchronous, active low; clears message state, target code to 268.
// ----------------------------------------------------------------------------
module diameter_header_avp_parser_unit #(
  parameter int POSITION_BITS = dhap_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dhap_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output dhap_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  logic [31:0]         target_code_r, target_code_nxt;
  logic                out_valid_r, out_valid_nxt;
  dhap_pkg::out_word_t out_word_r, out_word_nxt;
  dhap_pkg::out_word_t res;
  logic                step;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall && in_word.last;
  assign step      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  dhap_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .in_word(in_word),
    .target (target_code_r),
    .res    (res)
  );

  always_comb begin
    target_code_nxt = target_code_r;
    if (cfg_valid && cfg_ready) begin
      target_code_nxt = cfg_data;
    end
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (step && in_word.last) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_code_r <= dhap_pkg::TARGET_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      target_code_r <= target_code_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

@@ rtl/dhap_checker.sv @@
// ----------------------------------------------------------------------------
// dhap_checker
// Port-level checks on the parser's channels, bound to the top level.
// ----------------------------------------------------------------------------
module dhap_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dhap_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input dhap_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("summary word changed while stalled");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == dhap_pkg::ST_SHORT |->
      !out_word.is_request && out_word.command_id == 24'd0 &&
      out_word.hop_by_hop == 32'd0 && out_word.result_value == 32'd0)
    else $error("short message summary carries nonzero fields");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != dhap_pkg::ST_FOUND |->
      out_word.result_value == 32'd0)
    else $error("result value nonzero without a match");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_word.last))
    else $error("summary word without an accepted last byte");

  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("summary valid right after reset");

endmodule

bind diameter_header_avp_parser_unit dhap_checker u_dhap_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
